// ===== hdl/ip_rng_pkg.sv =====
// Package for the IPv4 range table lookup: field widths, command codes, controller states
// and the command and status structs between the controller and the datapath.
// Depends on nothing; every other file of the block imports it.
package ip_rng_pkg;

    // Default depth of the range entry table.
    localparam int ENTRY_DEPTH_DEF = 4096;

    // Prefix table: one start index per first octet.
    localparam int PREFIX_COUNT_C = 256;
    localparam int PREFIX_W       = 8;

    // Field widths.
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 24;
    localparam int LENGTH_W = 8;
    localparam int ENTRY_W  = ADDR_W + LENGTH_W + OFFSET_W;

    // Stream widths.
    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 48;

    typedef enum logic [S_TUSER_W-1:0] {
        CMD_LOAD_PREFIX = 2'd0,
        CMD_LOAD_RANGE  = 2'd1,
        CMD_LOOKUP      = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic wr_prefix;
        logic wr_range;
        logic rd_prefix;
        logic scan_start;
        logic scan_step;
        logic set_hit;
        logic set_miss;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic prefix_idx_ok;
        logic range_idx_ok;
        logic start_ok;
        logic next_ok;
        logic hit;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/ipv4_range_table_lookup.sv =====
// Top level of the IPv4 range table lookup: controller and datapath joined.
// Depends on ip_rng_pkg, ip_rng_ctrl and ip_rng_dp.
//
// Channel   Direction  Transfer when          Content
// s_axis    in         tvalid and tready      tuser: command; tdata: load or lookup fields
// m_axis    out        tvalid and tready      tuser: found; tdata: match, offset, length
// cfg       in         i_cfg_wr_en            entry_count, no handshake
//
// A load command is taken in the idle state, and the block stays ready for more.
// A lookup first reads the prefix table; then the scan compares one entry a cycle,
// bound by the single read port of the range table. A lookup whose start index is
// at or beyond the limit skips the scan and gives a not-found result. Reset is
// synchronous and clears the control state, the entry count and the result valid
// flag; the tables are not cleared and hold whatever they held. A stalled result
// waits in the output register, and the scan holds its last entry until that
// register is free.
module ipv4_range_table_lookup #(
    parameter int ENTRY_DEPTH = ip_rng_pkg::ENTRY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // command [1:0]
    input  logic [ip_rng_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // write_index [11:0], load_start [23:12], end_address [55:24],
    // offset_in [79:56], length_in [87:80], ip_address [119:88]
    input  logic [ip_rng_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // found [0]
    output logic                             o_m_axis_tuser,
    // matched_entry [11:0], record_offset [35:12], record_length [43:36], zero [47:44]
    output logic [ip_rng_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [ip_rng_pkg::COUNT_W-1:0]   i_cfg_wr_data
);
    import ip_rng_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The controller decides which table is written, when the scan starts and
    // steps, and when a result is loaded into the output register.
    ip_rng_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath owns both tables, the scan index and the result register.
    ip_rng_dp #(
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_s_tuser     (i_s_axis_tuser),
        .i_s_tdata     (i_s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_tuser     (o_m_axis_tuser)
    );

endmodule

// ===== hdl/ip_rng_dp.sv =====
// Datapath of the IPv4 range table lookup: both tables, the scan counter, the
// entry count register and the result register. Depends on ip_rng_pkg.
module ip_rng_dp #(
    parameter int ENTRY_DEPTH = ip_rng_pkg::ENTRY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ip_rng_pkg::t_dp_cmd              i_cmd,
    output ip_rng_pkg::t_dp_status           o_status,
    input  logic [ip_rng_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic [ip_rng_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [ip_rng_pkg::COUNT_W-1:0]   i_cfg_wr_data,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ip_rng_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tuser
);
    import ip_rng_pkg::*;

    localparam int IDX_W = $clog2(ENTRY_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(ENTRY_DEPTH);

    logic [INDEX_W-1:0]  w_write_index;
    logic [INDEX_W-1:0]  w_load_start;
    logic [ADDR_W-1:0]   w_end_address;
    logic [OFFSET_W-1:0] w_offset_in;
    logic [LENGTH_W-1:0] w_length_in;
    logic [ADDR_W-1:0]   w_ip_address;

    logic [INDEX_W-1:0]  r_prefix_mem [PREFIX_COUNT_C];
    logic [ENTRY_W-1:0]  r_range_mem  [ENTRY_DEPTH];
    logic [INDEX_W-1:0]  r_prefix_q;
    logic [ENTRY_W-1:0]  r_entry_q;
    logic [ADDR_W-1:0]   r_addr;
    logic [CNT_W-1:0]    r_idx;
    logic [COUNT_W-1:0]  r_entry_count;

    logic                r_m_valid;
    logic                r_found;
    logic [INDEX_W-1:0]  r_match;
    logic [OFFSET_W-1:0] r_offset;
    logic [LENGTH_W-1:0] r_length;

    logic [CMP_W-1:0]    w_windex_ext;
    logic [CMP_W-1:0]    w_start_ext;
    logic [CMP_W-1:0]    w_count_ext;
    logic [CMP_W-1:0]    w_limit;
    logic [CMP_W-1:0]    w_idx_ext;
    logic [CNT_W-1:0]    w_idx_next;
    logic [IDX_W-1:0]    w_rd_addr;

    assign w_write_index = i_s_tdata[11:0];
    assign w_load_start  = i_s_tdata[23:12];
    assign w_end_address = i_s_tdata[55:24];
    assign w_offset_in   = i_s_tdata[79:56];
    assign w_length_in   = i_s_tdata[87:80];
    assign w_ip_address  = i_s_tdata[119:88];

    assign w_windex_ext = CMP_W'(w_write_index);
    assign w_start_ext  = CMP_W'(r_prefix_q);
    assign w_count_ext  = CMP_W'(r_entry_count);
    assign w_limit      = (w_count_ext > DEPTH_C) ? DEPTH_C : w_count_ext;
    assign w_idx_ext    = CMP_W'(r_idx);
    assign w_idx_next   = r_idx + CNT_W'(1);
    assign w_rd_addr    = i_cmd.scan_start ? w_start_ext[IDX_W-1:0] : w_idx_next[IDX_W-1:0];

    // Prefix table.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_prefix) begin
            r_prefix_mem[w_write_index[PREFIX_W-1:0]] <= w_load_start;
        end
        if (i_cmd.rd_prefix) begin
            r_prefix_q <= r_prefix_mem[w_ip_address[ADDR_W-1 -: PREFIX_W]];
        end
    end

    // Range entry table; the read runs one entry ahead of the compare.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_range) begin
            r_range_mem[w_windex_ext[IDX_W-1:0]] <= {w_end_address, w_length_in, w_offset_in};
        end
        if (i_cmd.scan_start || i_cmd.scan_step) begin
            r_entry_q <= r_range_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_prefix) begin
            r_addr <= w_ip_address;
        end
        if (i_cmd.scan_start) begin
            r_idx <= w_start_ext[CNT_W-1:0];
        end else if (i_cmd.scan_step) begin
            r_idx <= w_idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.set_hit || i_cmd.set_miss) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_hit) begin
            r_found  <= 1'b1;
            r_match  <= w_idx_ext[INDEX_W-1:0];
            r_offset <= r_entry_q[OFFSET_W-1:0];
            r_length <= r_entry_q[OFFSET_W +: LENGTH_W];
        end else if (i_cmd.set_miss) begin
            r_found  <= 1'b0;
            r_match  <= '0;
            r_offset <= '0;
            r_length <= '0;
        end
    end

    always_comb begin
        o_status.cmd           = t_cmd'(i_s_tuser);
        o_status.prefix_idx_ok = (w_write_index[INDEX_W-1:PREFIX_W] == '0);
        o_status.range_idx_ok  = (w_windex_ext < DEPTH_C);
        o_status.start_ok      = (w_start_ext < w_limit);
        o_status.next_ok       = (CMP_W'(w_idx_next) < w_limit);
        o_status.hit           = (r_entry_q[ENTRY_W-1 -: ADDR_W] >= r_addr);
        o_status.out_free      = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_found;
    assign o_m_tdata  = {{(M_TDATA_W - INDEX_W - OFFSET_W - LENGTH_W){1'b0}},
                         r_length, r_offset, r_match};

endmodule

// ===== hdl/ip_rng_ctrl.sv =====
// Controller of the IPv4 range table lookup: accepts commands and sequences
// the prefix read and the entry scan. Depends on ip_rng_pkg.
module ip_rng_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  ip_rng_pkg::t_dp_status i_status,
    output ip_rng_pkg::t_dp_cmd    o_cmd
);
    import ip_rng_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    case (i_status.cmd)
                        CMD_LOAD_PREFIX: o_cmd.wr_prefix = i_status.prefix_idx_ok;
                        CMD_LOAD_RANGE:  o_cmd.wr_range  = i_status.range_idx_ok;
                        CMD_LOOKUP: begin
                            o_cmd.rd_prefix = 1'b1;
                            n_state         = ST_PREFIX;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREFIX: begin
                if (i_status.start_ok) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else if (i_status.out_free) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // A finished result waits here until the output register is free.
                if (i_status.hit) begin
                    if (i_status.out_free) begin
                        o_cmd.set_hit = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else if (i_status.next_ok) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/ip_rng_chk.sv =====
// Port-level checks for the IPv4 range table lookup, bound to the top level.
// Depends on ip_rng_pkg and ipv4_range_table_lookup.
module ip_rng_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [ip_rng_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic                             o_m_axis_tuser,
    input logic [ip_rng_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import ip_rng_pkg::*;

    logic w_s_xfer;

    assign w_s_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result holds.
    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // A not-found result carries zero index, offset and length.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("not-found result with non-zero payload");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer && (i_s_axis_tuser != CMD_LOOKUP) && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result after a load command");

    // A lookup keeps the block busy for at least the prefix read.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer && (i_s_axis_tuser == CMD_LOOKUP) |=> !o_s_axis_tready)
        else $error("ready straight after a lookup transfer");

    // A new result only appears while the block was busy with lookup work, never out of idle.
    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind ipv4_range_table_lookup ip_rng_chk u_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for ipv4_range_table_lookup: loads both tables over the input
// stream, reprograms the entry count between phases and checks every lookup result.
// Depends on ip_rng_pkg and the RTL of the block; no other files are read.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ip_rng_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 1650;
    // The fourth command code has no meaning; the block must swallow it.
    localparam logic [S_TUSER_W-1:0] CMD_UNUSED = 2'd3;

    // One transfer on the input stream, every field present whatever the command.
    typedef struct packed {
        logic [S_TUSER_W-1:0] cmd;
        logic [INDEX_W-1:0]   widx;
        logic [INDEX_W-1:0]   start;
        logic [ADDR_W-1:0]    last_addr;
        logic [OFFSET_W-1:0]  off;
        logic [LENGTH_W-1:0]  len;
        logic [ADDR_W-1:0]    addr;
    } stim_item_t;

    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  entry;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } lookup_result_t;

    // Keeps a shadow copy of both tables and the entry count, works out the answer
    // to each accepted lookup and compares it with what comes out of the block.
    class lookup_scoreboard;
        bit [INDEX_W-1:0]  prefix_start  [PREFIX_COUNT_C];
        bit                prefix_loaded [PREFIX_COUNT_C];
        bit [ADDR_W-1:0]   range_last    [ENTRY_DEPTH_DEF];
        bit [OFFSET_W-1:0] range_offset  [ENTRY_DEPTH_DEF];
        bit [LENGTH_W-1:0] range_length  [ENTRY_DEPTH_DEF];
        bit                range_loaded  [ENTRY_DEPTH_DEF];
        int unsigned       scan_limit;
        lookup_result_t    pending_results [$];
        int                failures;

        function void set_entry_count(logic [COUNT_W-1:0] count);
            scan_limit = (count > ENTRY_DEPTH_DEF) ? ENTRY_DEPTH_DEF : count;
        endfunction

        // The clean flag drops when the prefix of the first octet was never loaded or the scan
        // would touch a table entry that was never loaded; such lookups are never sent.
        function lookup_result_t resolve_lookup(logic [ADDR_W-1:0] addr, output bit clean);
            int unsigned    idx;
            lookup_result_t res;
            res   = '0;
            clean = prefix_loaded[addr[31:24]];
            idx   = prefix_start[addr[31:24]];
            while (idx < scan_limit) begin
                if (!range_loaded[idx]) begin
                    clean = 1'b0;
                    break;
                end
                if (range_last[idx] >= addr) begin
                    res.found  = 1'b1;
                    res.entry  = idx[INDEX_W-1:0];
                    res.offset = range_offset[idx];
                    res.length = range_length[idx];
                    break;
                end
                idx++;
            end
            return res;
        endfunction

        function void note_transfer(stim_item_t it);
            bit clean;
            case (it.cmd)
                CMD_LOAD_PREFIX: begin
                    if (it.widx < PREFIX_COUNT_C) begin
                        prefix_start[it.widx[PREFIX_W-1:0]]  = it.start;
                        prefix_loaded[it.widx[PREFIX_W-1:0]] = 1'b1;
                    end
                end
                CMD_LOAD_RANGE: begin
                    range_last[it.widx]   = it.last_addr;
                    range_offset[it.widx] = it.off;
                    range_length[it.widx] = it.len;
                    range_loaded[it.widx] = 1'b1;
                end
                CMD_LOOKUP: pending_results.push_back(resolve_lookup(it.addr, clean));
                default: ;
            endcase
        endfunction

        task report(string msg);
            failures++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic found, logic [M_TDATA_W-1:0] data);
            lookup_result_t want;
            if (pending_results.size() == 0) begin
                report("result transfer with no lookup outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (found !== want.found)
                report($sformatf("found %b, expected %b", found, want.found));
            if (data[11:0] !== want.entry)
                report($sformatf("matched_entry %0d, expected %0d", data[11:0], want.entry));
            if (data[35:12] !== want.offset)
                report($sformatf("record_offset %h, expected %h", data[35:12], want.offset));
            if (data[43:36] !== want.length)
                report($sformatf("record_length %h, expected %h", data[43:36], want.length));
            if (data[47:44] !== 4'h0)
                report($sformatf("padding bits %b, expected zero", data[47:44]));
        endtask
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tready    = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;

    lookup_scoreboard sb = new();
    int idle_pct;
    int sink_stall;
    int quiet_cycles;
    int counted_items;

    ipv4_range_table_lookup dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Gap length for either side: none unless a draw against idle_pct says so, then a short
    // gap or now and then a long one. With idle_pct at zero both sides run flat out.
    function automatic int idle_gap();
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Fields that the command does not use are random as well, so that every bit of
    // the input data toggles.
    function automatic stim_item_t random_fields(logic [S_TUSER_W-1:0] cmd);
        stim_item_t it;
        it.cmd       = cmd;
        it.widx      = INDEX_W'($urandom);
        it.start     = INDEX_W'($urandom);
        it.last_addr = $urandom;
        it.off       = OFFSET_W'($urandom);
        it.len       = LENGTH_W'($urandom);
        it.addr      = $urandom;
        return it;
    endfunction

    // Presents one item and waits for its transfer. The valid is never lowered after a
    // transfer here; the next call, or the drain, decides what it does in that step.
    task automatic push(stim_item_t it);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.addr, it.len, it.off, it.last_addr, it.start, it.widx};
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_transfer(it);
        if (it.cmd == CMD_LOAD_RANGE || it.cmd == CMD_LOOKUP ||
            (it.cmd == CMD_LOAD_PREFIX && it.widx < PREFIX_COUNT_C)) begin
            counted_items++;
        end
    endtask

    task automatic push_prefix(int octet, int first);
        stim_item_t it;
        it       = random_fields(CMD_LOAD_PREFIX);
        it.widx  = INDEX_W'(octet);
        it.start = INDEX_W'(first);
        push(it);
    endtask

    task automatic push_range(int idx, logic [ADDR_W-1:0] last, logic [OFFSET_W-1:0] off,
                              logic [LENGTH_W-1:0] len);
        stim_item_t it;
        it           = random_fields(CMD_LOAD_RANGE);
        it.widx      = INDEX_W'(idx);
        it.last_addr = last;
        it.off       = off;
        it.len       = len;
        push(it);
    endtask

    task automatic push_lookup(logic [ADDR_W-1:0] addr);
        stim_item_t it;
        it      = random_fields(CMD_LOOKUP);
        it.addr = addr;
        push(it);
    endtask

    // Items the block must ignore: the unused command, or a prefix load beyond the
    // prefix table.
    task automatic push_ignored();
        stim_item_t it;
        it = random_fields(CMD_UNUSED);
        if ($urandom_range(0, 1) == 1) begin
            it.cmd  = CMD_LOAD_PREFIX;
            it.widx = INDEX_W'($urandom_range(PREFIX_COUNT_C, 4095));
        end
        push(it);
    endtask

    // Holds the sender back until every outstanding lookup has answered, and then longer,
    // so that a load still in flight has finished as well.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entry_count(logic [COUNT_W-1:0] count);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_entry_count(count);
    endtask

    // One phase: a fresh sorted run of range entries somewhere in the table, prefix
    // starts that point into it, a new entry count, then lookups aimed mostly at and
    // around the loaded end addresses, mixed with stray loads and ignored items.
    task automatic random_phase();
        int              nent;
        int              base;
        int              nlook;
        int              pick;
        int              k;
        int              tries;
        int              first;
        int              span;
        logic [31:0]     lo;
        logic [31:0]     addr;
        logic [31:0]     ends [$];
        int              order [$];
        bit              octet_used [PREFIX_COUNT_C];
        bit              clean;
        lookup_result_t  unused_res;

        case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            2:       idle_pct = 30;
            default: idle_pct = 60;
        endcase

        nent = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(2, 40);
        pick = $urandom_range(0, 7);
        if (pick == 0) base = 0;
        else if (pick == 1) base = ENTRY_DEPTH_DEF - nent;
        else base = $urandom_range(0, ENTRY_DEPTH_DEF - nent);

        // End addresses either spread over the whole space or packed into a few
        // consecutive first octets, which gives long buckets.
        span = $urandom_range(1, 4);
        lo   = {8'($urandom_range(0, 251)), 24'h0};
        for (k = 0; k < nent; k++) begin
            if (pick[0]) ends.push_back($urandom);
            else ends.push_back(lo + 32'($urandom_range(0, span * (1 << 24) - 1)));
            order.push_back(k);
        end
        ends.sort();
        if ($urandom_range(0, 1) == 1) ends[nent-1] = 32'hFFFF_FFFF;
        order.shuffle();

        pick = $urandom_range(0, 99);
        if (pick < 40) write_entry_count(COUNT_W'(base + nent));
        else if (pick < 55) write_entry_count(COUNT_W'($urandom_range(base, base + nent)));
        else if (pick < 60) write_entry_count('0);
        else if (pick < 70) write_entry_count(COUNT_W'(ENTRY_DEPTH_DEF));
        else if (pick < 75) write_entry_count({COUNT_W{1'b1}});
        else if (pick < 80) write_entry_count(COUNT_W'($urandom_range(4097, 8191)));
        else write_entry_count(COUNT_W'($urandom_range(0, ENTRY_DEPTH_DEF)));

        foreach (order[i]) begin
            if ($urandom_range(0, 7) == 0) push_ignored();
            push_range(base + order[i], ends[order[i]], OFFSET_W'($urandom),
                       LENGTH_W'($urandom));
        end

        foreach (ends[i]) octet_used[ends[i][31:24]] = 1'b1;
        repeat (3) octet_used[$urandom_range(0, PREFIX_COUNT_C - 1)] = 1'b1;
        for (int o = 0; o < PREFIX_COUNT_C; o++) begin
            if (!octet_used[o]) continue;
            // Normally the first entry that can cover the octet; sometimes a start
            // that skips entries, or one anywhere in the table.
            first = base + nent;
            for (k = nent - 1; k >= 0; k--) begin
                if (ends[k] >= {8'(o), 24'h0}) first = base + k;
            end
            pick = $urandom_range(0, 15);
            if (pick < 2) first = $urandom_range(base, base + nent - 1);
            else if (pick == 2) first = $urandom_range(0, ENTRY_DEPTH_DEF - 1);
            push_prefix(o, first);
        end

        nlook = $urandom_range(15, 50);
        repeat (nlook) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                push_ignored();
            end else if (pick == 1) begin
                push_prefix($urandom_range(0, PREFIX_COUNT_C - 1), $urandom_range(0, 4095));
            end else if (pick == 2) begin
                push_range($urandom_range(0, ENTRY_DEPTH_DEF - 1), $urandom,
                           OFFSET_W'($urandom), LENGTH_W'($urandom));
            end else begin
                // Lookups whose scan would reach a never-loaded entry are redrawn.
                for (tries = 0; tries < 16; tries++) begin
                    k    = $urandom_range(0, nent - 1);
                    pick = $urandom_range(0, 9);
                    if (pick < 5) addr = ends[k] + 32'($urandom_range(0, 2)) - 32'd1;
                    else if (pick < 8) addr = {ends[k][31:24], 24'($urandom)};
                    else addr = $urandom;
                    unused_res = sb.resolve_lookup(addr, clean);
                    if (clean) break;
                end
                if (clean) push_lookup(addr);
            end
            if ($urandom_range(0, 39) == 0) drain_results();
        end
    endtask

    // Result side: transfers are checked at the edge where they happen, and the
    // ready is withdrawn for random stretches.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall--;
        end else begin
            sink_stall = idle_gap();
            m_tready <= (sink_stall == 0);
            if (sink_stall > 0) sink_stall--;
        end
    end

    // A long stretch with no transfer on either stream means the block has hung or
    // a result has gone missing.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. With the entry count still at its reset value of zero a lookup
        // scans nothing and must miss.
        push_prefix(0, 0);
        push_prefix(255, 4095);
        push_ignored();
        push(random_fields(CMD_UNUSED));
        push_range(0, 32'h0000_0000, 24'hFF_FFFF, 8'hFF);
        push_range(1, 32'hFFFF_FFFF, 24'h00_0000, 8'h00);
        push_range(4095, 32'hFFFF_FFFF, 24'hA5_A5A5, 8'h5A);
        push_lookup(32'h0000_0000);

        write_entry_count(COUNT_W'(ENTRY_DEPTH_DEF));
        push_lookup(32'h0000_0000);
        push_lookup(32'h0000_0001);
        push_lookup(32'h00FF_FFFF);
        push_lookup(32'hFFFF_FFFF);

        // A count of one: the scan runs out before a match, and a start at the top of
        // the table is already beyond the limit.
        write_entry_count(COUNT_W'(1));
        push_lookup(32'h0000_0005);
        push_lookup(32'hFFFF_FFFF);

        // Counts above the table depth behave as the full depth.
        write_entry_count({COUNT_W{1'b1}});
        push_lookup(32'hFF00_0000);
        push_lookup(32'h0000_0000);
        write_entry_count(COUNT_W'(ENTRY_DEPTH_DEF + 1));
        push_lookup(32'hFFFF_FFFF);

        while (counted_items < ITEM_TARGET) random_phase();

        drain_results();
        repeat (16) @(posedge clk);
        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
